// File: rtl/slab_block_allocator_unit_macros.svh
// Assertion macros shared by the slab allocator RTL.
`ifndef SLAB_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define SLAB_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sba_pkg.sv
// Shared types, constants and the size class table of the slab allocator.
package sba_pkg;

  localparam int unsigned NUM_PAGES_DEF   = 256;
  localparam int unsigned NUM_CLASSES     = 24;
  localparam int unsigned PAGE_ID_W       = 13;
  localparam int unsigned WORD_OFF_W      = 10;
  localparam int unsigned USED_W          = 10;
  localparam logic [PAGE_ID_W-1:0] NULL_PAGE = '1;
  localparam logic [11:0] MAX_SMALL_BYTES = 12'd1016;
  localparam logic [9:0]  HEADER_WORDS    = 10'd5;
  localparam logic [12:0] HEADER_BYTES    = 13'd20;
  localparam logic [12:0] PAGE_BYTES      = 13'd4096;

  // Block size of each class in 4-byte words.
  localparam logic [7:0] CLASS_WORDS [NUM_CLASSES] = '{
    8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd10, 8'd12, 8'd14, 8'd16, 8'd20,
    8'd24, 8'd28, 8'd32, 8'd40, 8'd48, 8'd56, 8'd78, 8'd101, 8'd127, 8'd169,
    8'd203, 8'd254
  };

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_PAGE  = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_e;

  typedef struct packed {
    logic        action;
    logic [11:0] size_bytes;
    logic [19:0] block_address;
  } in_t;

  typedef struct packed {
    logic [19:0] address;
    logic [1:0]  status;
    logic [4:0]  size_class;
  } out_t;

  // One page's bookkeeping word.
  typedef struct packed {
    logic                  in_use;
    logic [4:0]            cls;
    logic [PAGE_ID_W-1:0]  prev;
    logic [PAGE_ID_W-1:0]  next;
    logic [USED_W-1:0]     used;
    logic [WORD_OFF_W-1:0] head;
  } page_rec_t;

  // Smallest class whose block covers the given word count.
  function automatic logic [4:0] size_to_class(logic [7:0] words);
    logic [4:0] cls;
    cls = 5'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (CLASS_WORDS[i] >= words) cls = 5'(i);
    end
    return cls;
  endfunction

endpackage

// File: rtl/slab_block_allocator_unit.sv
// Alloc from the current page: S_A_CUR, S_A_CURW, S_POP_WR, S_RESP, output register;
// free: S_F_CHK, then S_RESP or the release states. A list walk adds S_WALK and S_WALKW
// per page visited; a new page adds S_SCAN and S_SCANW per page scanned, S_CARVE per
// carved block (up to 509), then S_PAGE_WR, S_LINK_WR and S_POP_RD. Requests: one word
// at a time; each step is bound by the page memory's read and write ports. Reset: control
// clears at once, then a clearing pass frees every page; no word is taken until it ends.
`include "slab_block_allocator_unit_macros.svh"

module slab_block_allocator_unit #(
  parameter int unsigned NUM_PAGES = sba_pkg::NUM_PAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sba_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sba_pkg::out_t out_data_o
);
  import sba_pkg::*;

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned FW = $clog2(NUM_PAGES + 1);
  localparam int unsigned BW = PW + WORD_OFF_W;
  localparam logic [PAGE_ID_W-1:0] NP_ID = PAGE_ID_W'(NUM_PAGES);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_A_CUR   = 5'd2;
  localparam logic [4:0] S_A_CURW  = 5'd3;
  localparam logic [4:0] S_WALK    = 5'd4;
  localparam logic [4:0] S_WALKW   = 5'd5;
  localparam logic [4:0] S_NEW     = 5'd6;
  localparam logic [4:0] S_SCAN    = 5'd7;
  localparam logic [4:0] S_SCANW   = 5'd8;
  localparam logic [4:0] S_CARVE   = 5'd9;
  localparam logic [4:0] S_PAGE_WR = 5'd10;
  localparam logic [4:0] S_LINK_WR = 5'd11;
  localparam logic [4:0] S_POP_RD  = 5'd12;
  localparam logic [4:0] S_POP_WR  = 5'd13;
  localparam logic [4:0] S_F_CHK   = 5'd14;
  localparam logic [4:0] S_REL_NX  = 5'd15;
  localparam logic [4:0] S_REL_NXW = 5'd16;
  localparam logic [4:0] S_REL_PV  = 5'd17;
  localparam logic [4:0] S_REL_PVW = 5'd18;
  localparam logic [4:0] S_REL_PG  = 5'd19;
  localparam logic [4:0] S_RESP    = 5'd20;

  // Control registers
  logic [4:0]           state_q, state_d;
  logic [PW-1:0]        cnt_q, cnt_d;
  logic [FW-1:0]        free_tot_q, free_tot_d;
  logic                 out_valid_q, out_valid_d;
  logic [PAGE_ID_W-1:0] cur_q  [NUM_CLASSES];
  logic [PAGE_ID_W-1:0] cur_d  [NUM_CLASSES];
  logic [PAGE_ID_W-1:0] last_q [NUM_CLASSES];
  logic [PAGE_ID_W-1:0] last_d [NUM_CLASSES];

  // Payload registers
  logic [4:0]            cls_q, cls_d;
  logic [PAGE_ID_W-1:0]  pg_q, pg_d;
  logic [PAGE_ID_W-1:0]  walk_q, walk_d;
  logic [WORD_OFF_W-1:0] w_q, w_d;
  logic [WORD_OFF_W-1:0] head_q, head_d;
  logic [12:0]           t_q, t_d;
  page_rec_t             rec_q, rec_d;
  out_t                  res_q, res_d;
  out_t                  out_q, out_d;

  // Page memory ports
  page_rec_t page_mem [NUM_PAGES];
  logic      pm_re, pm_we;
  logic [PW-1:0] pm_raddr, pm_waddr;
  page_rec_t pm_wdata, pm_rdata_q;

  // Block link memory ports
  logic [WORD_OFF_W-1:0] blk_mem [NUM_PAGES * (1 << WORD_OFF_W)];
  logic                  bl_re, bl_we;
  logic [BW-1:0]         bl_raddr, bl_waddr;
  logic [WORD_OFF_W-1:0] bl_wdata, bl_rdata_q;

  logic                  in_fire, out_free;
  logic [12:0]           size_sum;
  logic [PAGE_ID_W-1:0]  fpg;
  logic [WORD_OFF_W-1:0] fw;
  logic [12:0]           bytes;
  logic [12:0]           t_end;
  page_rec_t             rd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign size_sum = 13'(in_data_i.size_bytes) + 13'd3;
  assign fpg      = PAGE_ID_W'(in_data_i.block_address[19:12]);
  assign fw       = in_data_i.block_address[11:2];
  assign bytes    = {3'b000, CLASS_WORDS[cls_q], 2'b00};
  assign t_end    = t_q + bytes;
  assign rd       = pm_rdata_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    free_tot_d  = free_tot_q;
    out_valid_d = out_valid_q;
    cur_d       = cur_q;
    last_d      = last_q;
    cls_d       = cls_q;
    pg_d        = pg_q;
    walk_d      = walk_q;
    w_d         = w_q;
    head_d      = head_q;
    t_d         = t_q;
    rec_d       = rec_q;
    res_d       = res_q;
    out_d       = out_q;
    pm_re       = 1'b0;
    pm_raddr    = pg_q[PW-1:0];
    pm_we       = 1'b0;
    pm_waddr    = pg_q[PW-1:0];
    pm_wdata    = rec_q;
    bl_re       = 1'b0;
    bl_raddr    = {pg_q[PW-1:0], rec_q.head};
    bl_we       = 1'b0;
    bl_waddr    = {pg_q[PW-1:0], t_q[11:2]};
    bl_wdata    = head_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = cnt_q;
        pm_wdata = '0;
        cnt_d    = cnt_q + PW'(1);
        if (cnt_q == PW'(NUM_PAGES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          if (in_data_i.action == ACT_ALLOC) begin
            if (in_data_i.size_bytes == 12'd0 || in_data_i.size_bytes > MAX_SMALL_BYTES) begin
              res_d.status = ST_BAD_SIZE;
              state_d      = S_RESP;
            end else begin
              cls_d   = size_to_class(size_sum[9:2]);
              state_d = S_A_CUR;
            end
          end else begin
            if (fpg >= NP_ID || fw < HEADER_WORDS) begin
              res_d.status = ST_BAD_ADDR;
              state_d      = S_RESP;
            end else begin
              pg_d     = fpg;
              w_d      = fw;
              pm_re    = 1'b1;
              pm_raddr = fpg[PW-1:0];
              state_d  = S_F_CHK;
            end
          end
        end
      end
      // Allocate: try the class's current page
      S_A_CUR: begin
        res_d.size_class = cls_q;
        if (cur_q[cls_q][PAGE_ID_W-1]) begin
          state_d = S_NEW;
        end else begin
          pg_d     = cur_q[cls_q];
          pm_re    = 1'b1;
          pm_raddr = cur_q[cls_q][PW-1:0];
          state_d  = S_A_CURW;
        end
      end
      S_A_CURW: begin
        if (rd.head != '0) begin
          rec_d    = rd;
          bl_re    = 1'b1;
          bl_raddr = {pg_q[PW-1:0], rd.head};
          state_d  = S_POP_WR;
        end else begin
          walk_d  = last_q[cls_q];
          state_d = S_WALK;
        end
      end
      // Walk the class list backward from the last page
      S_WALK: begin
        if (walk_q[PAGE_ID_W-1]) begin
          state_d = S_NEW;
        end else begin
          pm_re    = 1'b1;
          pm_raddr = walk_q[PW-1:0];
          state_d  = S_WALKW;
        end
      end
      S_WALKW: begin
        if (rd.head != '0) begin
          cur_d[cls_q] = walk_q;
          pg_d         = walk_q;
          rec_d        = rd;
          bl_re        = 1'b1;
          bl_raddr     = {walk_q[PW-1:0], rd.head};
          state_d      = S_POP_WR;
        end else begin
          walk_d  = rd.prev;
          state_d = S_WALK;
        end
      end
      // Find the lowest free page
      S_NEW: begin
        if (free_tot_q == '0) begin
          res_d.status = ST_NO_PAGE;
          state_d      = S_RESP;
        end else begin
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        pm_re    = 1'b1;
        pm_raddr = cnt_q;
        state_d  = S_SCANW;
      end
      S_SCANW: begin
        if (!rd.in_use) begin
          pg_d    = PAGE_ID_W'(cnt_q);
          t_d     = HEADER_BYTES;
          head_d  = '0;
          state_d = S_CARVE;
        end else begin
          cnt_d   = cnt_q + PW'(1);
          state_d = S_SCAN;
        end
      end
      // Carve one block per cycle, highest block ends as head
      S_CARVE: begin
        if (t_end <= PAGE_BYTES) begin
          bl_we  = 1'b1;
          head_d = t_q[11:2];
          t_d    = t_end;
        end else begin
          rec_d.in_use = 1'b1;
          rec_d.cls    = cls_q;
          rec_d.prev   = last_q[cls_q];
          rec_d.next   = NULL_PAGE;
          rec_d.used   = '0;
          rec_d.head   = head_q;
          state_d      = S_PAGE_WR;
        end
      end
      S_PAGE_WR: begin
        pm_we         = 1'b1;
        free_tot_d    = free_tot_q - FW'(1);
        last_d[cls_q] = pg_q;
        cur_d[cls_q]  = pg_q;
        if (!rec_q.prev[PAGE_ID_W-1]) begin
          pm_re    = 1'b1;
          pm_raddr = rec_q.prev[PW-1:0];
          state_d  = S_LINK_WR;
        end else begin
          state_d = S_POP_RD;
        end
      end
      S_LINK_WR: begin
        pm_we         = 1'b1;
        pm_waddr      = rec_q.prev[PW-1:0];
        pm_wdata      = rd;
        pm_wdata.next = pg_q;
        state_d       = S_POP_RD;
      end
      S_POP_RD: begin
        bl_re   = 1'b1;
        state_d = S_POP_WR;
      end
      // Pop the head block and report it
      S_POP_WR: begin
        pm_we         = 1'b1;
        pm_wdata.head = bl_rdata_q;
        pm_wdata.used = rec_q.used + USED_W'(1);
        res_d.address = {pg_q[7:0], rec_q.head, 2'b00};
        res_d.status  = ST_OK;
        state_d       = S_RESP;
      end
      // Free: reject a page not in use, else push the block or release the page
      S_F_CHK: begin
        if (!rd.in_use) begin
          res_d.status = ST_BAD_ADDR;
          state_d      = S_RESP;
        end else if (rd.used > USED_W'(1)) begin
          bl_we         = 1'b1;
          bl_waddr      = {pg_q[PW-1:0], w_q};
          bl_wdata      = rd.head;
          pm_we         = 1'b1;
          pm_wdata      = rd;
          pm_wdata.head = w_q;
          pm_wdata.used = rd.used - USED_W'(1);
          state_d       = S_RESP;
        end else begin
          rec_d   = rd;
          state_d = S_REL_NX;
        end
      end
      S_REL_NX: begin
        if (!rec_q.next[PAGE_ID_W-1]) begin
          pm_re    = 1'b1;
          pm_raddr = rec_q.next[PW-1:0];
          state_d  = S_REL_NXW;
        end else begin
          state_d = S_REL_PV;
        end
      end
      S_REL_NXW: begin
        pm_we         = 1'b1;
        pm_waddr      = rec_q.next[PW-1:0];
        pm_wdata      = rd;
        pm_wdata.prev = rec_q.prev;
        state_d       = S_REL_PV;
      end
      S_REL_PV: begin
        if (!rec_q.prev[PAGE_ID_W-1]) begin
          pm_re    = 1'b1;
          pm_raddr = rec_q.prev[PW-1:0];
          state_d  = S_REL_PVW;
        end else begin
          state_d = S_REL_PG;
        end
      end
      S_REL_PVW: begin
        pm_we         = 1'b1;
        pm_waddr      = rec_q.prev[PW-1:0];
        pm_wdata      = rd;
        pm_wdata.next = rec_q.next;
        state_d       = S_REL_PG;
      end
      S_REL_PG: begin
        pm_we           = 1'b1;
        pm_wdata.in_use = 1'b0;
        free_tot_d      = free_tot_q + FW'(1);
        if (rec_q.cls < 5'(NUM_CLASSES)) begin
          if (last_q[rec_q.cls] == pg_q) last_d[rec_q.cls] = rec_q.prev;
          if (cur_q[rec_q.cls] == pg_q) cur_d[rec_q.cls] = rec_q.prev;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      free_tot_q  <= FW'(NUM_PAGES);
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cur_q[i]  <= NULL_PAGE;
        last_q[i] <= NULL_PAGE;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      free_tot_q  <= free_tot_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    cls_q  <= cls_d;
    pg_q   <= pg_d;
    walk_q <= walk_d;
    w_q    <= w_d;
    head_q <= head_d;
    t_q    <= t_d;
    rec_q  <= rec_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Page memory
  always_ff @(posedge clk_i) begin
    if (pm_we) page_mem[pm_waddr] <= pm_wdata;
    if (pm_re) pm_rdata_q <= page_mem[pm_raddr];
  end

  // Block link memory
  always_ff @(posedge clk_i) begin
    if (bl_we) blk_mem[bl_waddr] <= bl_wdata;
    if (bl_re) bl_rdata_q <= blk_mem[bl_raddr];
  end

  `SBA_ASSERT_NEXT(a_busy_after_accept, in_fire, state_q != S_IDLE, "idle right after accept")
  `SBA_ASSERT_NOW(a_free_total_range, 1'b1, free_tot_q <= FW'(NUM_PAGES), "free total overflow")
  `SBA_ASSERT_NOW(a_scan_has_page, state_q == S_SCAN, free_tot_q != '0, "scan with empty pool")
  `SBA_ASSERT_NOW(a_err_zero_addr, out_valid_o && out_data_o.status != ST_OK,
                  out_data_o.address == '0, "error word with address")
  `SBA_ASSERT_NOW(a_no_accept_clr, state_q == S_CLR, !in_ready_o, "ready during clear")

endmodule
